// ===== src/sbal_pkg.sv =====
// Package for the stack block allocator: field widths, request kinds,
// default parameter values and the result record.
// No dependencies.
package sbal_pkg;

  // Field widths
  localparam int unsigned ADDR_W = 25;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned KIND_W = 2;

  // Default sizing
  localparam int unsigned DEF_MAX_BLOCKS = 64;
  localparam int unsigned DEF_MEM_BYTES  = 16777216;
  localparam int unsigned DEF_ALLOC_BASE = 16384;

  // Reset value of the max_blocks register
  localparam logic [CFG_W-1:0] CFG_MAX_BLOCKS_RST = 7'd64;

  // Block granule: lengths are rounded up to 32 bytes
  localparam int unsigned GRAN_MASK = 31;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INIT   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DEINIT = 2'd3;

  // One result transaction
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              ok;
    logic [ADDR_W-1:0] freed_length;
  } res_t;

endpackage

// ===== src/sbal_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the length stack; no dependencies.
module sbal_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/stack_block_allocator_top.sv =====
// Stack block allocator: LIFO allocator with the length stack held in RAM.
// Alloc, init, deinit and failed free write their result straight into the output register if it is free;
// a successful free first reads the stack RAM in state READ, then writes its result.
// Throughput: one transaction per cycle while in_stall is low; a successful free or a held result raises it.
// Reset clears the top pointer, count, ready flag and capacity; max_blocks
// resets to 64. The stack RAM is not cleared; entries are read only once pushed.
// Depends on sbal_pkg and sbal_ram.
module stack_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = sbal_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned MEM_BYTES  = sbal_pkg::DEF_MEM_BYTES,
  parameter int unsigned ALLOC_BASE = sbal_pkg::DEF_ALLOC_BASE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sbal_pkg::CFG_W-1:0]   cfg_max_blocks_i,
  // Request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sbal_pkg::KIND_W-1:0]  kind_i,
  input  logic [sbal_pkg::LEN_W-1:0]   req_length_i,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sbal_pkg::ADDR_W-1:0]  address_o,
  output logic                         ok_o,
  output logic [sbal_pkg::ADDR_W-1:0]  freed_length_o
);

  import sbal_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned RND_W = LEN_W + 1;

  localparam logic [ADDR_W-1:0] MemTop  = ADDR_W'(MEM_BYTES);
  localparam logic [ADDR_W-1:0] BaseAdr = ADDR_W'(ALLOC_BASE);
  localparam logic [CNT_W-1:0]  CntMax  = CNT_W'(MAX_BLOCKS);
  localparam logic [RND_W-1:0]  RndAdd  = RND_W'(GRAN_MASK);

  // Controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CFG_W-1:0]  max_blocks_q;
  logic [ADDR_W-1:0] top_q, top_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic              ready_q, ready_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              in_fire;
  logic              slot_free;
  logic              exec;
  logic              free_ok;
  logic [RND_W-1:0]  rounded;
  logic [ADDR_W-1:0] room;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  used_dec;

  // Configuration register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blocks_q <= CFG_MAX_BLOCKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_blocks_q <= cfg_max_blocks_i;
    end
  end

  // Handshake helpers
  assign in_stall  = (state_q != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid_q || !out_stall;
  assign free_ok   = ready_q && (used_q != '0);
  assign used_dec  = used_q - CNT_W'(1);

  // Round the request to the granule in 33-bit arithmetic
  assign rounded = ({1'b0, req_length_i} + RndAdd) & ~RndAdd;
  assign room    = (top_q >= MemTop) ? '0 : (MemTop - top_q);

  // Stack RAM access: push on alloc, read the top entry on free
  assign ram_waddr = used_q[IDX_W-1:0];
  assign ram_raddr = used_dec[IDX_W-1:0];
  assign ram_re    = in_fire && (kind_i == KIND_FREE) && free_ok;

  // Execute the request and update the allocator state
  always_comb begin
    top_d   = top_q;
    used_d  = used_q;
    cap_d   = cap_q;
    ready_d = ready_q;
    res_d   = '0;
    exec    = 1'b0;
    ram_we  = 1'b0;
    if (state_q == ST_READ) begin
      exec         = 1'b1;
      used_d       = used_dec;
      top_d        = (ram_rdata > top_q) ? '0 : (top_q - ram_rdata);
      res_d.address      = top_d;
      res_d.ok           = 1'b1;
      res_d.freed_length = ram_rdata;
    end else if (in_fire && !ram_re) begin
      exec = 1'b1;
      unique case (kind_i)
        KIND_ALLOC: begin
          if (ready_q && (used_q < cap_q) && (rounded <= {{(RND_W-ADDR_W){1'b0}}, room})) begin
            ram_we        = 1'b1;
            used_d        = used_q + CNT_W'(1);
            top_d         = top_q + rounded[ADDR_W-1:0];
            res_d.address = top_q;
            res_d.ok      = 1'b1;
          end
        end
        KIND_FREE: begin
          res_d.address = top_q;
        end
        KIND_INIT: begin
          if (!ready_q) begin
            top_d   = BaseAdr;
            used_d  = '0;
            ready_d = 1'b1;
            cap_d   = (32'(max_blocks_q) > 32'(MAX_BLOCKS)) ? CntMax
                                                             : CNT_W'(max_blocks_q);
          end
          res_d.address = BaseAdr;
          res_d.ok      = 1'b1;
        end
        KIND_DEINIT: begin
          ready_d  = 1'b0;
          res_d.ok = 1'b1;
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  // Sequence: a successful free passes through READ; park a result when the output register is occupied
  always_comb begin
    state_d     = state_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall;
    unique case (state_q)
      ST_IDLE: begin
        if (ram_re) begin
          state_d = ST_READ;
        end else if (exec && slot_free) begin
          out_d       = res_d;
          out_valid_d = 1'b1;
        end else if (exec) begin
          state_d = ST_HOLD;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          out_d       = res_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      used_q      <= '0;
      cap_q       <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      used_q      <= used_d;
      cap_q       <= cap_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (exec) begin
      res_q <= res_d;
    end
  end

  // Length stack
  sbal_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_BLOCKS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rounded[ADDR_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid      = out_valid_q;
  assign address_o      = out_q.address;
  assign ok_o           = out_q.ok;
  assign freed_length_o = out_q.freed_length;

  // Assertions
  a_used_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= cap_q) else $error("stack count exceeds capacity");

  a_top_in_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= MemTop) else $error("top pointer beyond memory");

  a_read_after_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> $past(ram_re))
    else $error("stack read state without a free transaction");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ready_q && (used_q < cap_q)))
    else $error("push into a full or unready stack");

  a_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re)) else $error("push and pop in the same cycle");

endmodule

// ===== tb/stack_block_allocator_checker.sv =====
// Checker for the stack block allocator: watches the configuration, request and
// result channels, predicts every result and compares it field by field.
// Depends on sbal_pkg.
module stack_block_allocator_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [sbal_pkg::CFG_W-1:0]   cfg_max_blocks_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [sbal_pkg::KIND_W-1:0]  kind_i,
  input  logic [sbal_pkg::LEN_W-1:0]   req_length_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [sbal_pkg::ADDR_W-1:0]  address_i,
  input  logic                         ok_i,
  input  logic [sbal_pkg::ADDR_W-1:0]  freed_length_i,
  output int                           outstanding_o,
  output int                           failures_o
);
  import sbal_pkg::*;

  localparam int unsigned STACK_DEPTH = DEF_MAX_BLOCKS;
  localparam int unsigned STACK_IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned MEM_SIZE    = DEF_MEM_BYTES;
  localparam int unsigned HEAP_BASE   = DEF_ALLOC_BASE;

  // Allocator state as the block should hold it
  logic [CFG_W-1:0]  max_blocks_q;
  logic [ADDR_W-1:0] top_ptr;
  int unsigned       used_blocks;
  int unsigned       capacity;
  logic              is_ready;
  logic [ADDR_W-1:0] block_lengths [STACK_DEPTH];

  res_t pending_results [$];
  int   results_seen;

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    failures_o++;
    $display("mismatch at result %0d: %s expected 0x%0h, got 0x%0h",
             results_seen, what, want_v, got_v);
  endtask

  // Apply one request to the state and return the result it should produce
  function automatic res_t predict_allocation(input logic [KIND_W-1:0] kind,
                                              input logic [LEN_W-1:0] len);
    logic [32:0]       rounded;
    logic [32:0]       room;
    logic [ADDR_W-1:0] popped;
    res_t              r;
    r = '0;
    case (kind)
      KIND_ALLOC: begin
        // round up to the granule in 33 bits so the largest length cannot wrap
        rounded = ({1'b0, len} + 33'(GRAN_MASK)) & ~33'(GRAN_MASK);
        room    = 33'(MEM_SIZE) - {8'b0, top_ptr};
        if (is_ready && used_blocks < capacity && used_blocks < STACK_DEPTH &&
            rounded <= room) begin
          r.address = top_ptr;
          r.ok      = 1'b1;
          block_lengths[used_blocks[STACK_IDX_W-1:0]] = rounded[ADDR_W-1:0];
          used_blocks++;
          top_ptr = top_ptr + rounded[ADDR_W-1:0];
        end
      end
      KIND_FREE: begin
        if (!is_ready || used_blocks == 0) begin
          r.address = top_ptr;
        end else begin
          used_blocks--;
          popped         = block_lengths[used_blocks[STACK_IDX_W-1:0]];
          top_ptr        = (popped > top_ptr) ? '0 : top_ptr - popped;
          r.address      = top_ptr;
          r.ok           = 1'b1;
          r.freed_length = popped;
        end
      end
      KIND_INIT: begin
        // a second init while ready leaves everything alone
        if (!is_ready) begin
          top_ptr     = ADDR_W'(HEAP_BASE);
          used_blocks = 0;
          capacity    = (32'(max_blocks_q) > STACK_DEPTH) ? STACK_DEPTH
                                                          : 32'(max_blocks_q);
          is_ready    = 1'b1;
        end
        r.address = ADDR_W'(HEAP_BASE);
        r.ok      = 1'b1;
      end
      default: begin
        is_ready = 1'b0;
        r.ok     = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Track writes and requests, compare results against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      max_blocks_q  = CFG_MAX_BLOCKS_RST;
      top_ptr       = '0;
      used_blocks   = 0;
      capacity      = 0;
      is_ready      = 1'b0;
      results_seen  = 0;
      failures_o    = 0;
      outstanding_o = 0;
      pending_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        max_blocks_q = cfg_max_blocks_i;
      if (out_valid_i && !out_stall_i) begin
        got.address      = address_i;
        got.ok           = ok_i;
        got.freed_length = freed_length_i;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, address", '0,
                          32'(got.address));
        end else begin
          want = pending_results.pop_front();
          if (got.address !== want.address)
            report_mismatch("address", 32'(want.address), 32'(got.address));
          if (got.ok !== want.ok)
            report_mismatch("ok", 32'(want.ok), 32'(got.ok));
          if (got.freed_length !== want.freed_length)
            report_mismatch("freed_length", 32'(want.freed_length),
                            32'(got.freed_length));
        end
        results_seen++;
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(predict_allocation(kind_i, req_length_i));
      outstanding_o = pending_results.size();
    end
  end

endmodule

// ===== tb/stack_block_allocator_top_test.sv =====
// Test top for the stack block allocator: drives requests, configuration writes
// and result back-pressure, and gives the verdict from the checker's count.
// Depends on sbal_pkg, stack_block_allocator_top and stack_block_allocator_checker.
module stack_block_allocator_top_test;
  import sbal_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_max_blocks;
  logic              in_valid;
  logic              in_stall;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  req_length;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] address;
  logic              ok;
  logic [ADDR_W-1:0] freed_length;

  int outstanding;
  int failures;
  int accepted_items = 0;
  int burst_left;
  bit gaps_on;

  stack_block_allocator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_blocks_i (cfg_max_blocks),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .kind_i           (kind),
    .req_length_i     (req_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .address_o        (address),
    .ok_o             (ok),
    .freed_length_o   (freed_length)
  );

  stack_block_allocator_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_max_blocks_i (cfg_max_blocks),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .req_length_i     (req_length),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .address_i        (address),
    .ok_i             (ok),
    .freed_length_i   (freed_length),
    .outstanding_o    (outstanding),
    .failures_o       (failures)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Guard against a hung run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Result back-pressure: random stall patterns, plus two long hold-offs
  initial begin
    stall_mode_e mode;
    int          span;
    int          hold_mark;
    int          holds_done;
    hold_mark  = 150;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 2));
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk_i);
        if (holds_done < 2 && accepted_items >= hold_mark) begin
          // hold off long enough for the block to fill and stall its input
          out_stall <= 1'b1;
          repeat (119) begin
            @(negedge clk_i);
            out_stall <= 1'b1;
          end
          holds_done++;
          hold_mark += 250;
        end else begin
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
            default:     out_stall <= ($urandom_range(0, 99) < 75);
          endcase
        end
      end
    end
  end

  // Offer one request and hold it until accepted; open a new burst when due
  task automatic send_request(input logic [KIND_W-1:0] k, input logic [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    kind       <= k;
    req_length <= len;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    accepted_items++;
  endtask

  // Drop valid and wait until every result has come back, then let the block settle
  task automatic wait_idle;
    in_valid  <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max_blocks(input logic [CFG_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_max_blocks <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: new capacity, fresh init, then random stretches of filling and draining
  task automatic run_phase(input logic [CFG_W-1:0] limit, input int n_items,
                           input bit gaps);
    logic [KIND_W-1:0] k;
    logic [LEN_W-1:0]  len;
    int                r;
    bit                filling;
    wait_idle();
    write_max_blocks(limit);
    gaps_on = gaps;
    filling = 1'b1;
    send_request(KIND_DEINIT, $urandom());
    send_request(KIND_INIT, $urandom());
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0)
        filling = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < (filling ? 70 : 25))
        k = KIND_ALLOC;
      else if (r < 92)
        k = KIND_FREE;
      else if (r < 97)
        k = KIND_INIT;
      else
        k = KIND_DEINIT;
      len = $urandom();
      if (k == KIND_ALLOC) begin
        // mostly small blocks, some large enough to exhaust the memory
        r = $urandom_range(0, 99);
        if (r < 50)
          len = $urandom_range(0, 512);
        else if (r < 75)
          len = $urandom_range(0, 32'hFFFFF);
        else if (r < 90)
          len = $urandom_range(0, 32'hFFFFFF);
      end
      send_request(k, len);
    end
  endtask

  // Stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_valid      = 1'b0;
    cfg_max_blocks = '0;
    in_valid       = 1'b0;
    kind           = KIND_ALLOC;
    req_length     = '0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Capacity above the stack depth, clamped at init
    write_max_blocks(7'd127);
    send_request(KIND_FREE, 32'h0);
    send_request(KIND_ALLOC, 32'h40);
    send_request(KIND_INIT, 32'h0);
    send_request(KIND_INIT, 32'hFFFFFFFF);
    send_request(KIND_ALLOC, 32'd0);
    send_request(KIND_ALLOC, 32'd1);
    send_request(KIND_ALLOC, 32'd33);
    send_request(KIND_ALLOC, 32'hFFFFFFFF);
    send_request(KIND_ALLOC, 32'hFFFFFFE1);
    // take exactly the room left after the base and 96 bytes
    send_request(KIND_ALLOC, DEF_MEM_BYTES - DEF_ALLOC_BASE - 96);
    send_request(KIND_ALLOC, 32'd1);
    send_request(KIND_ALLOC, 32'd0);
    repeat (6) send_request(KIND_FREE, 32'hFFFFFFFF);
    send_request(KIND_DEINIT, 32'h0);
    send_request(KIND_FREE, 32'h0);
    send_request(KIND_ALLOC, 32'd32);

    // Zero capacity: every alloc fails as full
    wait_idle();
    write_max_blocks(7'd0);
    send_request(KIND_INIT, 32'h0);
    send_request(KIND_ALLOC, 32'd32);

    // Capacity of one: second alloc finds the stack full
    wait_idle();
    write_max_blocks(7'd1);
    send_request(KIND_DEINIT, 32'h0);
    send_request(KIND_INIT, 32'h0);
    send_request(KIND_ALLOC, 32'd64);
    send_request(KIND_ALLOC, 32'd64);

    // Random phases over several capacities
    run_phase(7'd64, 110, 1'b1);
    run_phase(7'd3, 100, 1'b1);
    run_phase(7'd127, 110, 1'b0);
    run_phase(CFG_W'($urandom_range(0, 127)), 100, 1'b1);
    run_phase(7'd1, 80, 1'b1);
    run_phase(7'd64, 120, 1'b1);

    // Drain and give the verdict
    wait_idle();
    repeat (10) @(negedge clk_i);
    if (failures == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/sbal_pkg.sv
src/sbal_ram.sv
src/stack_block_allocator_top.sv
tb/stack_block_allocator_checker.sv
tb/stack_block_allocator_top_test.sv
